>>> sv/srrw_pkg.sv
// Shared constants and register codes of the selective-repeat receiver window.
`timescale 1ns / 1ps

package srrw_pkg;

	// Default size of the sequence space (depth of the received map).
	localparam int SEQ_SPACE_DEF = 16;

	// Field widths.
	localparam int SEQ_W      = 16;
	localparam int CFG_W      = 5;
	localparam int BASE_OUT_W = 5;
	localparam int CFG_IDX_W  = 1;

	// Width used for window and length compares; holds any base, sum or length.
	localparam int CMP_W = SEQ_W + 1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS = 1'd1;

	// Register reset values.
	localparam logic [CFG_W-1:0] WINDOW_SIZE_RST   = 5'd4;
	localparam logic [CFG_W-1:0] TOTAL_PACKETS_RST = 5'd10;

endpackage

>>> sv/srrw_ifs.sv
// Valid/ready channel interfaces for arriving packets and acknowledgement results.
`timescale 1ns / 1ps

interface srrw_in_if;
	logic                        valid;
	logic                        ready;
	logic [srrw_pkg::SEQ_W-1:0]  seq_num;

	modport source(output valid, output seq_num, input ready);
	modport sink(input valid, input seq_num, output ready);
endinterface

interface srrw_out_if;
	logic                             valid;
	logic                             ready;
	logic                             ack_valid;
	logic [srrw_pkg::SEQ_W-1:0]       ack_seq;
	logic [srrw_pkg::BASE_OUT_W-1:0]  base_now;
	logic                             done_res;

	modport source(output valid, output ack_valid, output ack_seq, output base_now,
		output done_res, input ready);
	modport sink(input valid, input ack_valid, input ack_seq, input base_now,
		input done_res, output ready);
endinterface

>>> sv/selective_repeat_receiver_window.sv
// Selective-repeat ARQ receiver window: received map in RAM, base slide by RAM scan.
// Flow: an ignored item goes from the idle state to the result state. A taken item passes
// through the scan and check states for each map entry the scan finds already received,
// then through scan and check to stop at a hole, or scan alone to stop at the transfer length.
// New items are taken only in the idle state: not while a scan runs or a result waits to load.
// Reset: asynchronous, then a clearing pass that zeroes every entry of the received map.
`timescale 1ns / 1ps

module selective_repeat_receiver_window #(
	parameter int SEQ_SPACE = srrw_pkg::SEQ_SPACE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [srrw_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [srrw_pkg::CFG_W-1:0]      cfg_wdata,
	srrw_in_if.sink                         arrival,
	srrw_out_if.source                      result
);

	// Address width of the received map and width of the window base, which can
	// reach SEQ_SPACE itself once the whole transfer is in.
	localparam int AW = $clog2(SEQ_SPACE);
	localparam int BW = $clog2(SEQ_SPACE + 1);
	localparam int CW = srrw_pkg::CMP_W;

	// Sequencer states.
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_CHK   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	logic [2:0]                 state_q;
	logic [AW-1:0]              clr_addr_q;
	logic [BW-1:0]              base_q;
	logic [srrw_pkg::CFG_W-1:0] window_size_q;
	logic [srrw_pkg::CFG_W-1:0] total_packets_q;

	// Item held while its base slide runs.
	logic [srrw_pkg::SEQ_W-1:0] seq_q;
	logic                       hit_q;

	// Output register.
	logic                                out_valid_q;
	logic                                ack_valid_q;
	logic [srrw_pkg::SEQ_W-1:0]          ack_seq_q;
	logic [srrw_pkg::BASE_OUT_W-1:0]     base_now_q;
	logic                                done_res_q;

	logic [CW-1:0] total_eff;
	logic [CW-1:0] base_ext;
	logic [CW-1:0] seq_ext;
	logic          base_open;
	logic          in_window;
	logic          in_fire;
	logic          out_free;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic          ram_wdata;
	logic          ram_re;
	logic [0:0]    ram_rdata;

	// The transfer length saturates at the size of the sequence space.
	assign total_eff = (CW'(total_packets_q) > CW'(SEQ_SPACE)) ? CW'(SEQ_SPACE)
		: CW'(total_packets_q);
	assign base_ext  = CW'(base_q);
	assign seq_ext   = CW'(arrival.seq_num);
	assign base_open = base_ext < total_eff;

	// A number is taken only while the transfer is open, inside the window and
	// below the transfer length; that last check also keeps the map index in range.
	assign in_window = base_open && (seq_ext >= base_ext)
		&& (seq_ext < base_ext + CW'(window_size_q)) && (seq_ext < total_eff);

	assign arrival.ready = (state_q == ST_IDLE);
	assign in_fire       = arrival.valid && arrival.ready;
	assign out_free      = !out_valid_q || result.ready;

	// The map is written either by the clearing pass or at the accept edge of an
	// item in the window. Reads happen only in later cycles, so a read never meets
	// a write to the same entry in the same cycle.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = arrival.seq_num[AW-1:0];
		ram_wdata = 1'b1;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = 1'b0;
		end else if (in_fire && in_window) begin
			ram_we = 1'b1;
		end
	end

	// A read is issued in the scan state only while the base lies below the length, so it fits the address.
	assign ram_re = (state_q == ST_SCAN) && base_open;

	srrw_ram #(
		.WIDTH(1),
		.DEPTH(SEQ_SPACE)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (base_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// Configuration registers; the user must write them only while idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q   <= srrw_pkg::WINDOW_SIZE_RST;
			total_packets_q <= srrw_pkg::TOTAL_PACKETS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				srrw_pkg::REG_WINDOW_SIZE:   window_size_q   <= cfg_wdata;
				srrw_pkg::REG_TOTAL_PACKETS: total_packets_q <= cfg_wdata;
			endcase
		end
	end

	// Sequencer. Every item taken in the window starts a scan; one whose number equals the base
	// first moves the base on by one. The scan is needed even when the number is not
	// the base: after the length was lowered and raised again, entries at the base may
	// already be marked. Each scan step reads the map at the base and, if that entry
	// was already received, moves the base on again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			base_q     <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(SEQ_SPACE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						if (in_window) begin
							if (seq_ext == base_ext) begin
								base_q <= base_q + BW'(1);
							end
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SCAN: begin
					state_q <= base_open ? ST_CHK : ST_OUT;
				end
				ST_CHK: begin
					if (ram_rdata[0]) begin
						base_q  <= base_q + BW'(1);
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The accepted number and its verdict wait here until the result is formed.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			seq_q <= arrival.seq_num;
			hit_q <= in_window;
		end
	end

	// Output register: loaded when the slide is over and the previous result
	// has gone; a waiting result holds the sequencer, so no next item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			ack_valid_q <= hit_q;
			ack_seq_q   <= hit_q ? seq_q : '0;
			base_now_q  <= srrw_pkg::BASE_OUT_W'(base_q);
			done_res_q  <= !base_open;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.ack_valid = ack_valid_q;
	assign result.ack_seq   = ack_seq_q;
	assign result.base_now  = base_now_q;
	assign result.done_res  = done_res_q;

	// The base moves by at most one entry per cycle and never moves back.
	a_base_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (base_q == $past(base_q)) || (base_q == $past(base_q) + BW'(1)))
		else $error("window base moved by more than one entry");

	// An acknowledged number always lies below the transfer length.
	a_ack_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ack_valid) |-> (CW'(result.ack_seq) < total_eff))
		else $error("acknowledged number at or past the transfer length");

	// A map read is only issued for an entry inside the transfer.
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> (base_ext < CW'(SEQ_SPACE)))
		else $error("map read beyond the sequence space");

	// Once an item is taken, no further item is taken in the next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !arrival.ready)
		else $error("item accepted while the previous one is still in work");

endmodule

>>> sv/srrw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module srrw_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = srrw_pkg::SEQ_SPACE_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> tb/tb_selective_repeat_receiver_window.sv
// Testbench for the selective-repeat receiver window: predicted acknowledgements versus the RTL.
`timescale 1ns / 1ps

module tb_selective_repeat_receiver_window;
	import srrw_pkg::*;

	// The received map is SEQ_SPACE_DEF deep. A base slide takes a scan and a check per entry,
	// so SETTLE_CYCLES grows with the depth to cover the longest base slide.
	localparam int DEPTH         = SEQ_SPACE_DEF;
	localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
	// Cycles without any handshake before the run is declared hung. The worst correct gap is
	// a full slide plus a long receiver stall, or a configuration pause; this is far above both.
	localparam int STALL_LIMIT   = 4000;
	// The random traffic runs in rounds, each with its own window and transfer length.
	localparam int N_ROUNDS      = 15;
	localparam int ROUND_ITEMS   = 100;

	typedef struct packed {
		logic                  ack_valid;
		logic [SEQ_W-1:0]      ack_seq;
		logic [BASE_OUT_W-1:0] base_now;
		logic                  done_res;
	} ack_t;

	// Keeps its own copy of the window state and the two registers, predicts one
	// acknowledgement per accepted packet and checks the results in order.
	class window_scoreboard;
		logic [CFG_W-1:0] win_size;
		logic [CFG_W-1:0] xfer_len;
		bit               received [DEPTH];
		int unsigned      base;
		ack_t             acks_due[$];
		int unsigned      errors;

		function new();
			win_size = WINDOW_SIZE_RST;
			xfer_len = TOTAL_PACKETS_RST;
			base     = 0;
			errors   = 0;
			foreach (received[i])
				received[i] = 1'b0;
		endfunction

		// The transfer length saturates at the size of the sequence space.
		function int unsigned limit();
			return (xfer_len > DEPTH) ? DEPTH : xfer_len;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_WINDOW_SIZE)
				win_size = val;
			else if (idx == REG_TOTAL_PACKETS)
				xfer_len = val;
		endfunction

		function void note_arrival(logic [SEQ_W-1:0] seq);
			ack_t        ack;
			int unsigned lim;
			lim = limit();
			ack = '0;
			if (base < lim && seq >= base && seq < base + win_size && seq < lim) begin
				received[seq] = 1'b1;
				ack.ack_valid = 1'b1;
				ack.ack_seq   = seq;
				while (base < lim && received[base])
					base++;
			end
			ack.base_now = base[BASE_OUT_W-1:0];
			ack.done_res = (base >= lim);
			acks_due.push_back(ack);
		endfunction

		task report(string what, ack_t got, ack_t want);
			errors++;
			if (errors <= 40)
				$display("mismatch in %s: got ack=%0b seq=%0d base=%0d done=%0b, want ack=%0b seq=%0d base=%0d done=%0b",
					what, got.ack_valid, got.ack_seq, got.base_now, got.done_res,
					want.ack_valid, want.ack_seq, want.base_now, want.done_res);
		endtask

		task check_result(ack_t got);
			ack_t want;
			if (acks_due.size() == 0) begin
				report("result with nothing outstanding", got, '0);
				return;
			end
			want = acks_due.pop_front();
			if (got.ack_valid !== want.ack_valid)
				report("ack_valid", got, want);
			if (got.ack_seq !== want.ack_seq)
				report("ack_seq", got, want);
			if (got.base_now !== want.base_now)
				report("base_now", got, want);
			if (got.done_res !== want.done_res)
				report("done_res", got, want);
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	srrw_in_if  arrival();
	srrw_out_if result();

	selective_repeat_receiver_window #(
		.SEQ_SPACE(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.arrival(arrival),
		.result(result)
	);

	window_scoreboard sb = new();

	// Percent of cycles in which the sender holds back and the receiver stalls.
	int unsigned sender_idle_pct;
	int unsigned receiver_idle_pct;
	int unsigned quiet_cycles;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The receiver drops ready at random, independent of whether a result is waiting.
	always @(posedge clk) begin
		result.ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	// Every handshake on the result channel is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready)
			sb.check_result('{result.ack_valid, result.ack_seq, result.base_now,
				result.done_res});
	end

	// Hang detection: any handshake, a register write or reset clears the count.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (arrival.valid && arrival.ready) ||
				(result.valid && result.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Offers one packet and returns at the edge where it is taken. Valid is only lowered
	// when the sender really idles, so back-to-back items keep it high without a glitch.
	// The prediction is made here, at the accepting edge, so the next pick sees the new state.
	task automatic send_seq(input logic [SEQ_W-1:0] seq);
		if ($urandom_range(99) < sender_idle_pct) begin
			arrival.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
		arrival.valid   <= 1'b1;
		arrival.seq_num <= seq;
		do
			@(posedge clk);
		while (!arrival.ready);
		sb.note_arrival(seq);
	endtask

	// Stops offering packets until every outstanding acknowledgement has come back.
	task automatic hold_until_drained();
		arrival.valid <= 1'b0;
		@(posedge clk);
		while (sb.acks_due.size() != 0)
			@(posedge clk);
	endtask

	// Registers are only touched when the block is quiet: everything drained and any
	// trailing base slide given time to finish.
	task automatic program_window(input logic [CFG_W-1:0] win, input logic [CFG_W-1:0] len);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_WINDOW_SIZE;
		cfg_wdata <= win;
		@(posedge clk);
		sb.write_reg(REG_WINDOW_SIZE, win);
		cfg_idx   <= REG_TOTAL_PACKETS;
		cfg_wdata <= len;
		@(posedge clk);
		sb.write_reg(REG_TOTAL_PACKETS, len);
		cfg_we    <= 1'b0;
	endtask

	// Mostly numbers inside the live part of the window, which mark entries and repeat
	// acknowledgements. The base itself is only sent when a slide is allowed, which keeps
	// the transfer from finishing early. The rest are numbers just outside the window,
	// at the transfer length, past the sequence space, or anywhere in the 16-bit range.
	function automatic logic [SEQ_W-1:0] pick_seq(input bit slide_ok);
		int unsigned b;
		int unsigned lim;
		int unsigned top;
		b   = sb.base;
		lim = sb.limit();
		top = b + sb.win_size;
		if (top > lim)
			top = lim;
		if (b < lim && $urandom_range(99) < 80) begin
			if (slide_ok && $urandom_range(99) < 8)
				return SEQ_W'(b);
			if (top > b + 1)
				return SEQ_W'($urandom_range(top - 1, b + 1));
		end
		case ($urandom_range(6))
			0: return {SEQ_W{1'b1}};
			1: return SEQ_W'(b + sb.win_size);
			2: return SEQ_W'(lim);
			3: return SEQ_W'(b - 1);
			4: return SEQ_W'($urandom_range(31, 16));
			default: return SEQ_W'($urandom_range(16'hFFFF, 0));
		endcase
	endfunction

	initial begin
		int unsigned      b;
		logic [CFG_W-1:0] win;
		logic [CFG_W-1:0] len;
		bit               slide_ok;

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = REG_WINDOW_SIZE;
		cfg_wdata         = '0;
		arrival.valid     = 1'b0;
		arrival.seq_num   = '0;
		result.ready      = 1'b0;
		quiet_cycles      = 0;
		sender_idle_pct   = 12;
		receiver_idle_pct = 80;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// After reset the block clears its received map, one entry per cycle.
		repeat (DEPTH + SETTLE_CYCLES) @(posedge clk);

		// Directed part, starting from the reset values: window of 4, transfer of 10.
		send_seq(16'hFFFF);     // far outside, ignored
		send_seq(16'd3);        // top of the window, accepted, base stays
		send_seq(16'd3);        // duplicate inside the window, acknowledged again
		send_seq(16'd4);        // one past the window, ignored
		send_seq(16'd1);
		send_seq(16'd0);        // base slides to the first hole at 2
		send_seq(16'd2);        // base slides over 3 to 4
		send_seq(16'h8000);

		// A zero window accepts nothing.
		program_window(5'd0, 5'd10);
		send_seq(16'd4);
		send_seq(16'd5);

		// A wide window still stops at the transfer length.
		program_window(5'd31, 5'd10);
		send_seq(16'd10);
		send_seq(16'd9);
		send_seq(16'd16);

		// Length lowered below the base: done is reported, inputs ignored, map kept.
		program_window(5'd31, 5'd3);
		send_seq(16'd5);

		// A zero length is done at once.
		program_window(5'd31, 5'd0);
		send_seq(16'd0);

		// A length past the sequence space saturates; the transfer resumes from base 4.
		program_window(5'd31, 5'd31);
		send_seq(16'd15);
		send_seq(16'd16);
		send_seq(16'd4);        // base moves to 5
		send_seq(16'h7FFF);

		// The smallest window holds only the base.
		program_window(5'd1, 5'd31);
		send_seq(16'd6);
		send_seq(16'd5);

		// Random rounds. Each round picks a window and mostly a length a little past the base, so
		// most items land on live entries. Slides are paced so the base crosses the sequence
		// space over the whole run instead of in the first rounds.
		for (int r = 0; r < N_ROUNDS; r++) begin
			if (r == N_ROUNDS / 3) begin
				sender_idle_pct   = 80;
				receiver_idle_pct = 12;
			end else if (r == 2 * N_ROUNDS / 3) begin
				sender_idle_pct   = 0;
				receiver_idle_pct = 0;
			end

			b = sb.base;
			case ($urandom_range(11))
				0:       win = 5'd0;
				1, 2:    win = 5'd31;
				default: win = CFG_W'($urandom_range(16, 1));
			endcase
			if (r == N_ROUNDS - 1)
				len = CFG_W'($urandom_range(31, 16));
			else if ($urandom_range(7) == 0)
				len = CFG_W'($urandom_range(b, 0));
			else if (b + 5 > DEPTH)
				len = CFG_W'($urandom_range(31, DEPTH));
			else
				len = CFG_W'(b + $urandom_range(5, 1));
			program_window(win, len);

			for (int i = 0; i < ROUND_ITEMS; i++) begin
				slide_ok = (i >= ROUND_ITEMS * 4 / 5) &&
					((r == N_ROUNDS - 1) || (sb.base * N_ROUNDS <= (r + 1) * DEPTH));
				// Now and then the sender waits for every acknowledgement to come back.
				if ($urandom_range(63) == 0)
					hold_until_drained();
				send_seq(pick_seq(slide_ok));
			end
		end

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.acks_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
